/* src/sgs_pkg.sv */
`timescale 1ns / 1ps

package sgs_pkg;

   localparam int MAX_AXES    = 8;
   localparam int MAX_BINS    = 64;
   localparam int MAX_STRATA  = 64;
   localparam int AXIS_W      = 3;
   localparam int BIN_IDX_W   = $clog2(MAX_BINS);
   localparam int EDGE_ADDR_W = AXIS_W + BIN_IDX_W;
   localparam int DIGIT_W     = $clog2(MAX_STRATA);

   localparam int REQ_DATA_W  = 136;
   localparam int RSP_DATA_W  = 88;
   localparam int CSR_ADDR_W  = 6;
   localparam int CSR_DATA_W  = 64;

   localparam logic [47:0] W48_MAX = '1;

   localparam logic [2:0] REG_BINS   = 3'd0;
   localparam logic [2:0] REG_STRATA = 3'd1;
   localparam logic [2:0] REG_POINTS = 3'd2;
   localparam logic [2:0] REG_AXES   = 3'd3;
   localparam logic [2:0] REG_JACOB  = 3'd4;
   localparam logic [2:0] REG_STEP   = 3'd5;

   typedef enum logic [1:0] {
      FUNC_EDGE   = 2'd0,
      FUNC_AXIS   = 2'd1,
      FUNC_SAMPLE = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POS,
      ST_SUM,
      ST_IDX,
      ST_MULW,
      ST_RC,
      ST_CRD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic cell_finished;
      logic sweep_done;
   } odo_flags_type;

endpackage

/* src/sgs_odometer.sv */
`timescale 1ns / 1ps

module sgs_odometer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [sgs_pkg::AXIS_W-1:0]    axis,
   input  logic [3:0]                    axes_used,
   input  logic [6:0]                    strata_used,
   input  logic [15:0]                   points_per_cell,
   output logic [sgs_pkg::DIGIT_W-1:0]   digit,
   output sgs_pkg::odo_flags_type        flags
);
   import sgs_pkg::*;

   logic [DIGIT_W-1:0] digits_ff [MAX_AXES];
   logic [DIGIT_W-1:0] digits_in [MAX_AXES];
   logic [15:0]        pic_ff;
   logic               sweep_ff;
   logic [16:0]        pic_next;
   logic               wrap;
   logic               found;

   assign digit = digits_ff[axis];

   // carry runs from the last axis in use towards axis zero
   always_comb begin
      pic_next = {1'b0, pic_ff} + 17'd1;
      wrap     = pic_next > {1'b0, points_per_cell};
      found    = 1'b0;
      for (int j = MAX_AXES - 1; j >= 0; j--) begin
         digits_in[j] = digits_ff[j];
         if ((4'(j) < axes_used) && !found) begin
            if (({1'b0, digits_ff[j]} + 7'd2) <= strata_used) begin
               digits_in[j] = digits_ff[j] + DIGIT_W'(1);
               found        = 1'b1;
            end else begin
               digits_in[j] = '0;
            end
         end
      end
      flags.cell_finished = wrap;
      flags.sweep_done    = wrap & (sweep_ff | ~found);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pic_ff   <= 16'd1;
         sweep_ff <= 1'b0;
         for (int j = 0; j < MAX_AXES; j++) begin
            digits_ff[j] <= '0;
         end
      end else if (advance) begin
         if (wrap) begin
            pic_ff   <= 16'd1;
            sweep_ff <= sweep_ff | ~found;
            for (int j = 0; j < MAX_AXES; j++) begin
               digits_ff[j] <= digits_in[j];
            end
         end else begin
            pic_ff <= pic_next[15:0];
         end
      end
   end

endmodule

/* src/stratified_grid_sampler_core.sv */
// VEGAS point generator. Load the grid first: one edge item (tuser 0) per bin upper edge of
// each axis, one axis item (tuser 1) per axis for origin and span; a sample of a bin whose
// edges were never written gives undefined coordinate and weight. Each sample item (tuser 2)
// handles one axis and returns one result item; write items return nothing. A sample item
// runs through the multiply chain position -> bin edge read -> interpolation -> scaling, with
// the running weight carried from one axis to the next, and no new item is taken until its
// result is loaded into the result register. The next item is taken while a result still
// waits on the result side. Registers lie at byte address 8*i
// (bins, strata, points per cell, axes, jacobian, stratum step); write them only while idle.
`timescale 1ns / 1ps

module stratified_grid_sampler_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // axis[2:0], bin[9:3], boundary[34:10], origin[66:35], span[98:67], uniform[130:99]
   input  logic [sgs_pkg::REQ_DATA_W-1:0]    req_tdata,
   // func[1:0]
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // coordinate[31:0], bin_chosen[38:32], weight[86:39]
   output logic [sgs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // cell_finished[0], sweep_done[1]
   output logic [1:0]                        rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sgs_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [sgs_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [sgs_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import sgs_pkg::*;

   // configuration
   logic [6:0]  bins_ff;
   logic [6:0]  strata_ff;
   logic [15:0] points_ff;
   logic [3:0]  axes_ff;
   logic [47:0] jacob_ff;
   logic [23:0] step_ff;
   logic        csr_wr;
   logic [6:0]  nb;
   logic [6:0]  ng;
   logic [3:0]  na;

   // input decode
   func_type              in_func;
   logic [AXIS_W-1:0]     in_axis;
   logic [6:0]            in_bin;
   logic [24:0]           in_bound;
   logic [31:0]           in_origin;
   logic [31:0]           in_span;
   logic [31:0]           in_uniform;
   logic                  accept;

   // memories
   logic [24:0]            edge_mem_ff [MAX_AXES * MAX_BINS];
   logic [63:0]            axis_mem_ff [MAX_AXES];
   logic                   edge_we;
   logic                   axis_we;
   logic [EDGE_ADDR_W-1:0] edge_waddr;
   logic [EDGE_ADDR_W-1:0] raddr_hi;
   logic [EDGE_ADDR_W-1:0] raddr_lo;
   logic [24:0]            edge_hi_q_ff;
   logic [24:0]            edge_lo_q_ff;
   logic [63:0]            axis_q_ff;

   // control
   state_type state_ff;
   state_type state_in;
   logic      out_load;
   logic      last_c;

   // datapath
   logic [AXIS_W-1:0]   axis_ff;
   logic [31:0]         uniform_ff;
   logic [DIGIT_W-1:0]  digit;
   logic [6:0]          dsel;
   logic [31:0]         ulow;
   logic [55:0]         p_lo_ff;
   logic [30:0]         p_hi_ff;
   logic [62:0]         xn_ff;
   logic [14:0]         ix;
   logic [6:0]          iaj_c;
   logic [14:0]         diff;
   logic                frac_sat;
   logic [6:0]          iaj_ff;
   logic                iaj_ge2_ff;
   logic [12:0]         fh_ff;
   logic [23:0]         fl_ff;
   logic [24:0]         lo_e;
   logic signed [25:0]  width;
   logic signed [39:0]  prod_fh_ff;
   logic signed [50:0]  prod_fl_ff;
   logic [31:0]         f_ff;
   logic [24:0]         lo_ff;
   logic signed [41:0]  rc_sum;
   logic signed [31:0]  rc_ff;
   logic [47:0]         w_base;
   logic [55:0]         wh_ff;
   logic [55:0]         wl_ff;
   logic signed [64:0]  cprod_ff;
   logic [56:0]         wsum;
   logic [47:0]         wp_ff;
   logic signed [41:0]  coord_sum;
   logic [31:0]         coord_c;
   odo_flags_type       flags;

   // result register
   logic        rsp_valid_ff;
   logic [31:0] rsp_coord_ff;
   logic [6:0]  rsp_bin_ff;
   logic [47:0] rsp_weight_ff;
   logic        rsp_last_ff;
   logic        rsp_cell_ff;
   logic        rsp_sweep_ff;

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bins_ff   <= 7'd64;
         strata_ff <= 7'd1;
         points_ff <= 16'd2;
         axes_ff   <= 4'd1;
         jacob_ff  <= 48'd65536;
         step_ff   <= 24'd4194304;
      end else if (csr_wr) begin
         case (csr_paddr[5:3])
            REG_BINS:   bins_ff   <= csr_pwdata[6:0];
            REG_STRATA: strata_ff <= csr_pwdata[6:0];
            REG_POINTS: points_ff <= csr_pwdata[15:0];
            REG_AXES:   axes_ff   <= csr_pwdata[3:0];
            REG_JACOB:  jacob_ff  <= csr_pwdata[47:0];
            REG_STEP:   step_ff   <= csr_pwdata[23:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[5:3])
         REG_BINS:   csr_prdata = 64'(bins_ff);
         REG_STRATA: csr_prdata = 64'(strata_ff);
         REG_POINTS: csr_prdata = 64'(points_ff);
         REG_AXES:   csr_prdata = 64'(axes_ff);
         REG_JACOB:  csr_prdata = 64'(jacob_ff);
         REG_STEP:   csr_prdata = 64'(step_ff);
         default:    csr_prdata = '0;
      endcase
   end

   assign nb = (bins_ff == 7'd0) ? 7'd1 :
               (bins_ff > 7'(MAX_BINS)) ? 7'(MAX_BINS) : bins_ff;
   assign ng = (strata_ff == 7'd0) ? 7'd1 :
               (strata_ff > 7'(MAX_STRATA)) ? 7'(MAX_STRATA) : strata_ff;
   assign na = (axes_ff == 4'd0) ? 4'd1 :
               (axes_ff > 4'(MAX_AXES)) ? 4'(MAX_AXES) : axes_ff;

   // ---------------------------------------------------------------- input
   assign in_func    = func_type'(req_tuser);
   assign in_axis    = req_tdata[2:0];
   assign in_bin     = req_tdata[9:3];
   assign in_bound   = req_tdata[34:10];
   assign in_origin  = req_tdata[66:35];
   assign in_span    = req_tdata[98:67];
   assign in_uniform = req_tdata[130:99];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   assign edge_we    = accept && (in_func == FUNC_EDGE) && (in_bin != 7'd0) &&
                       (in_bin <= 7'(MAX_BINS));
   assign edge_waddr = {in_axis, BIN_IDX_W'(in_bin - 7'd1)};
   assign axis_we    = accept && (in_func == FUNC_AXIS);

   // ---------------------------------------------------------------- memories
   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem_ff[edge_waddr] <= in_bound;
      end
      if (state_ff == ST_IDX) begin
         edge_hi_q_ff <= edge_mem_ff[raddr_hi];
         edge_lo_q_ff <= edge_mem_ff[raddr_lo];
      end
   end

   always_ff @(posedge clock) begin
      if (axis_we) begin
         axis_mem_ff[in_axis] <= {in_span, in_origin};
      end
      if (state_ff == ST_POS) begin
         axis_q_ff <= axis_mem_ff[axis_ff];
      end
   end

   // ---------------------------------------------------------------- control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      out_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (in_func == FUNC_SAMPLE)) begin
               state_in = ST_POS;
            end
         end
         ST_POS:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_IDX;
         ST_IDX:  state_in = ST_MULW;
         ST_MULW: state_in = ST_RC;
         ST_RC:   state_in = ST_CRD;
         ST_CRD:  state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign last_c = ({1'b0, axis_ff} + 4'd1) >= na;

   sgs_odometer u_odometer (
      .clock           (clock),
      .reset           (reset),
      .advance         (out_load & last_c),
      .axis            (axis_ff),
      .axes_used       (na),
      .strata_used     (ng),
      .points_per_cell (points_ff),
      .digit           (digit),
      .flags           (flags)
   );

   // ---------------------------------------------------------------- datapath
   // (digit + 1) * 2^32 - u split as high part and 32-bit low part
   assign dsel = (uniform_ff == 32'd0) ? ({1'b0, digit} + 7'd1) : {1'b0, digit};
   assign ulow = ~uniform_ff + 32'd1;

   assign ix       = xn_ff[62:48];
   assign iaj_c    = (ix > 15'(nb)) ? nb : ix[6:0];
   assign diff     = ix - 15'(iaj_c);
   assign frac_sat = (diff[14:13] != 2'd0);
   assign raddr_hi = {axis_ff, BIN_IDX_W'(iaj_c - 7'd1)};
   assign raddr_lo = {axis_ff, BIN_IDX_W'(iaj_c - 7'd2)};

   assign lo_e  = iaj_ge2_ff ? edge_lo_q_ff : 25'd0;
   assign width = $signed({1'b0, edge_hi_q_ff}) - $signed({1'b0, lo_e});

   assign rc_sum = $signed({17'd0, lo_ff}) + 42'(prod_fh_ff) + 42'(prod_fl_ff >>> 24);

   assign w_base = (axis_ff == '0) ? jacob_ff : wp_ff;
   assign wsum   = 57'(wh_ff) + 57'(wl_ff[55:24]);

   assign coord_sum = 42'($signed(axis_q_ff[31:0])) + 42'(cprod_ff >>> 24);
   assign coord_c   = (coord_sum > 42'sd2147483647)  ? 32'h7FFF_FFFF :
                      (coord_sum < -42'sd2147483648) ? 32'h8000_0000 : coord_sum[31:0];

   always_ff @(posedge clock) begin
      if (accept) begin
         axis_ff    <= in_axis;
         uniform_ff <= in_uniform;
      end
      if (state_ff == ST_POS) begin
         p_lo_ff <= {24'd0, ulow} * {32'd0, step_ff};
         p_hi_ff <= {24'd0, dsel} * {7'd0, step_ff};
      end
      if (state_ff == ST_SUM) begin
         xn_ff <= {p_hi_ff, 32'd0} + 63'(p_lo_ff) + (63'd1 << 48);
      end
      if (state_ff == ST_IDX) begin
         iaj_ff     <= iaj_c;
         iaj_ge2_ff <= (iaj_c >= 7'd2);
         fh_ff      <= frac_sat ? '1 : diff[12:0];
         fl_ff      <= frac_sat ? '1 : xn_ff[47:24];
      end
      if (state_ff == ST_MULW) begin
         prod_fh_ff <= $signed({1'b0, fh_ff}) * width;
         prod_fl_ff <= $signed({1'b0, fl_ff}) * width;
         f_ff       <= (width > 26'sd0) ? ({25'd0, nb} * {7'd0, width[24:0]}) : 32'd0;
         lo_ff      <= lo_e;
      end
      if (state_ff == ST_RC) begin
         if (rc_sum > 42'sd1073741824) begin
            rc_ff <= 32'sd1073741824;
         end else if (rc_sum < -42'sd1073741824) begin
            rc_ff <= -32'sd1073741824;
         end else begin
            rc_ff <= rc_sum[31:0];
         end
         wh_ff <= {32'd0, w_base[47:24]} * {24'd0, f_ff};
         wl_ff <= {32'd0, w_base[23:0]} * {24'd0, f_ff};
      end
      if (state_ff == ST_CRD) begin
         cprod_ff <= rc_ff * $signed({1'b0, axis_q_ff[63:32]});
      end
   end

   // running weight
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
      end else if (state_ff == ST_CRD) begin
         wp_ff <= (wsum > {9'd0, W48_MAX}) ? W48_MAX : wsum[47:0];
      end
   end

   // ---------------------------------------------------------------- result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_coord_ff  <= coord_c;
         rsp_bin_ff    <= iaj_ff;
         rsp_weight_ff <= wp_ff;
         rsp_last_ff   <= last_c;
         rsp_cell_ff   <= last_c & flags.cell_finished;
         rsp_sweep_ff  <= last_c & flags.sweep_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_weight_ff, rsp_bin_ff, rsp_coord_ff};
   assign rsp_tuser  = {rsp_sweep_ff, rsp_cell_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* bench/tb_stratified_grid_sampler_core.sv */
`timescale 1ns / 1ps

module tb_stratified_grid_sampler_core;
   import sgs_pkg::*;

   localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 400;
   localparam longint unsigned FRAC_MAX = (64'd1 << 37) - 64'd1;
   localparam longint RC_LIM = 64'sd1073741824;
   localparam longint COORD_MAX = 64'sd2147483647;
   localparam longint COORD_MIN = -64'sd2147483648;

   // packed so that axis lands in the lowest bits of tdata
   typedef struct packed {
      logic [31:0] uniform;
      logic [31:0] span;
      logic [31:0] origin;
      logic [24:0] boundary;
      logic [6:0]  bin;
      logic [2:0]  axis;
   } req_fields_type;

   typedef struct packed {
      logic [31:0] coord;
      logic [6:0]  bin;
      logic [47:0] weight;
      logic        last;
      logic        cell_wrap;
      logic        sweep;
   } draw_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   stratified_grid_sampler_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // grid map and odometer as the block should hold them
   logic [6:0]  cfg_bins = 7'd64;
   logic [6:0]  cfg_strata = 7'd1;
   logic [15:0] cfg_ppc = 16'd2;
   logic [3:0]  cfg_axes = 4'd1;
   logic [47:0] cfg_jac = 48'd65536;
   logic [23:0] cfg_step = 24'd4194304;

   logic [24:0] grid_map [MAX_AXES][MAX_BINS];
   logic [31:0] axis_org [MAX_AXES];
   logic [31:0] axis_span [MAX_AXES];
   logic [5:0]  digit [MAX_AXES] = '{default: '0};
   int unsigned pts_in_cell = 1;
   logic [47:0] run_weight = '0;
   logic        swept = 1'b0;

   draw_result_type pending_draws [$];

   int req_idle_pct = 35;
   int rsp_idle_pct = 50;
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int errors = 0;
   int n_draws = 0;
   int n_writes = 0;
   int n_wraps = 0;
   int n_sweeps = 0;
   int n_settings = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_draws.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("ERROR %s: got %h, want %h", what, got, want);
      errors++;
   endtask

   function automatic longint unsigned clamp_to(input longint unsigned v, lo, hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic draw_result_type map_draw(input logic [2:0] ax, input logic [31:0] u);
      draw_result_type r;
      longint unsigned nb, nax, ng, pos, bsel, frac, fac, wh, wl;
      longint lo_e, hi_e, width, rc, prod, crd;
      int j;
      bit carry;
      nb = clamp_to(64'(cfg_bins), 1, MAX_BINS);
      nax = clamp_to(64'(cfg_axes), 1, MAX_AXES);
      ng = clamp_to(64'(cfg_strata), 1, MAX_STRATA);
      pos = ((64'(digit[ax]) + 64'd1) << 32) - 64'(u);
      pos = pos * 64'(cfg_step) + (64'd1 << 48);
      bsel = clamp_to(pos >> 48, 1, nb);
      frac = (pos - (bsel << 48)) >> 24;
      if (frac > FRAC_MAX)
         frac = FRAC_MAX;
      hi_e = longint'(grid_map[ax][bsel-1]);
      if (bsel >= 2)
         lo_e = longint'(grid_map[ax][bsel-2]);
      else
         lo_e = 0;
      width = hi_e - lo_e;
      rc = (lo_e <<< 24) + longint'(frac) * width;
      rc = rc >>> 24;
      if (rc > RC_LIM)
         rc = RC_LIM;
      if (rc < -RC_LIM)
         rc = -RC_LIM;
      prod = rc * longint'(axis_span[ax]);
      prod = prod >>> 24;
      crd = longint'($signed(axis_org[ax])) + prod;
      if (crd > COORD_MAX)
         crd = COORD_MAX;
      if (crd < COORD_MIN)
         crd = COORD_MIN;
      r.coord = crd[31:0];
      r.bin = bsel[6:0];

      if (ax == 0)
         run_weight = cfg_jac;
      fac = (width > 0) ? nb * 64'(width) : 64'd0;
      wh = 64'(run_weight[47:24]) * fac;
      wl = (64'(run_weight[23:0]) * fac) >> 24;
      if (wh > 64'(W48_MAX) || wl > 64'(W48_MAX) - wh)
         run_weight = W48_MAX;
      else
         run_weight = 48'(wh + wl);
      r.weight = run_weight;

      r.last = (64'(ax) + 64'd1 >= nax);
      r.cell_wrap = 1'b0;
      r.sweep = 1'b0;
      if (r.last) begin
         pts_in_cell++;
         if (pts_in_cell > 32'(cfg_ppc)) begin
            pts_in_cell = 1;
            carry = 1'b1;
            for (j = int'(nax) - 1; j >= 0 && carry; j--) begin
               if (64'(digit[j]) + 64'd2 <= ng) begin
                  digit[j] = digit[j] + 6'd1;
                  carry = 1'b0;
               end else begin
                  digit[j] = '0;
               end
            end
            if (carry)
               swept = 1'b1;
            r.cell_wrap = 1'b1;
            r.sweep = swept;
         end
      end
      return r;
   endfunction

   function automatic void apply_item(input logic [1:0] fn, input req_fields_type f);
      case (fn)
         FUNC_EDGE: begin
            if (f.bin >= 1 && f.bin <= MAX_BINS)
               grid_map[f.axis][f.bin-1] = f.boundary;
            n_writes++;
         end
         FUNC_AXIS: begin
            axis_org[f.axis] = f.origin;
            axis_span[f.axis] = f.span;
            n_writes++;
         end
         FUNC_SAMPLE: begin
            pending_draws.push_back(map_draw(f.axis, f.uniform));
            n_draws++;
         end
         default: n_writes++;
      endcase
   endfunction

   function automatic req_fields_type any_fields();
      req_fields_type f;
      f.uniform = $urandom;
      f.span = $urandom;
      f.origin = $urandom;
      f.boundary = 25'($urandom);
      f.bin = 7'($urandom);
      f.axis = 3'($urandom);
      return f;
   endfunction

   function automatic logic [31:0] pick_uniform();
      case ($urandom_range(9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(input logic [1:0] fn, input req_fields_type f);
      int gap;
      gap = ($urandom_range(99) < req_idle_pct) ? $urandom_range(4, 1) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= fn;
      req_tdata <= {5'b0, f};
      do @(posedge clock); while (!req_tready);
      apply_item(fn, f);
   endtask

   task automatic send_draw(input logic [2:0] ax, input logic [31:0] u);
      req_fields_type f;
      f = any_fields();
      f.axis = ax;
      f.uniform = u;
      send_item(FUNC_SAMPLE, f);
   endtask

   task automatic send_edge(input logic [2:0] ax, input logic [6:0] b, input logic [24:0] val);
      req_fields_type f;
      f = any_fields();
      f.axis = ax;
      f.bin = b;
      f.boundary = val;
      send_item(FUNC_EDGE, f);
   endtask

   task automatic send_axis(input logic [2:0] ax, input logic [31:0] org,
                            input logic [31:0] span);
      req_fields_type f;
      f = any_fields();
      f.axis = ax;
      f.origin = org;
      f.span = span;
      send_item(FUNC_AXIS, f);
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_draws.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic set_register(input logic [2:0] idx, input logic [63:0] val);
      logic [63:0] got, want;
      case (idx)
         REG_BINS:   begin cfg_bins = val[6:0];    want = 64'(val[6:0]);  end
         REG_STRATA: begin cfg_strata = val[6:0];  want = 64'(val[6:0]);  end
         REG_POINTS: begin cfg_ppc = val[15:0];    want = 64'(val[15:0]); end
         REG_AXES:   begin cfg_axes = val[3:0];    want = 64'(val[3:0]);  end
         REG_JACOB:  begin cfg_jac = val[47:0];    want = 64'(val[47:0]); end
         default:    begin cfg_step = val[23:0];   want = 64'(val[23:0]); end
      endcase
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== want)
         report("register readback", got, want);
   endtask

   // receiver: random stalls, plus long hold-offs on request
   always @(negedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      draw_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_draws.size() == 0) begin
            report("result with nothing pending", 64'(rsp_tdata[31:0]), '0);
         end else begin
            e = pending_draws.pop_front();
            if (rsp_tdata[31:0] !== e.coord)
               report("coordinate", 64'(rsp_tdata[31:0]), 64'(e.coord));
            if (rsp_tdata[38:32] !== e.bin)
               report("bin_chosen", 64'(rsp_tdata[38:32]), 64'(e.bin));
            if (rsp_tdata[86:39] !== e.weight)
               report("weight", 64'(rsp_tdata[86:39]), 64'(e.weight));
            if (rsp_tlast !== e.last)
               report("last_axis", 64'(rsp_tlast), 64'(e.last));
            if (rsp_tuser[0] !== e.cell_wrap)
               report("cell_finished", 64'(rsp_tuser[0]), 64'(e.cell_wrap));
            if (rsp_tuser[1] !== e.sweep)
               report("sweep_done", 64'(rsp_tuser[1]), 64'(e.sweep));
            if (e.cell_wrap)
               n_wraps++;
            if (e.sweep)
               n_sweeps++;
         end
      end
   end

   // every edge and every axis written before any draw reads them
   task automatic test_grid_load();
      logic [24:0] val;
      for (int a = 0; a < MAX_AXES; a++) begin
         send_axis(3'(a), $urandom_range(32'h00FF_FFFF) - 32'h0080_0000,
                   $urandom_range(32'h0100_0000));
         for (int b = 1; b <= MAX_BINS; b++) begin
            if (b == MAX_BINS)
               val = 25'h100_0000;
            else
               val = (25'(b) << 18) - 25'($urandom_range(32'h0002_0000));
            send_edge(3'(a), 7'(b), val);
         end
      end
   endtask

   task automatic test_directed();
      // weight from zero: no axis 0 yet; axis beyond the last one in use
      send_draw(3'd3, $urandom);
      // past the last bin, then the very bottom
      send_draw(3'd0, 32'h0000_0000);
      send_draw(3'd0, 32'hFFFF_FFFF);
      send_item(FUNC_UNKNOWN, any_fields());
      // out-of-range bin indexes are dropped
      send_edge(3'd2, 7'd0, 25'h1FF_FFFF);
      send_edge(3'd2, 7'd65, 25'h1FF_FFFF);
      send_edge(3'd2, 7'd127, 25'h1FF_FFFF);
      send_draw(3'd2, 32'h0000_0000);
      // widest and empty bins, saturating coordinates
      send_edge(3'd7, 7'd64, 25'h1FF_FFFF);
      send_edge(3'd7, 7'd1, 25'h000_0000);
      send_axis(3'd7, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_draw(3'd7, 32'h0000_0000);
      send_draw(3'd7, 32'hFFFF_FFFF);
      send_edge(3'd6, 7'd64, 25'h000_0000);
      send_axis(3'd6, 32'h8000_0000, 32'hFFFF_FFFF);
      send_draw(3'd6, 32'h0000_0000);
      send_draw(3'd0, 32'h8000_0000);
   endtask

   task automatic random_traffic(input int count);
      int done, pick, nax;
      logic [6:0] b;
      logic [24:0] val;
      done = 0;
      while (done < count) begin
         nax = int'(clamp_to(64'(cfg_axes), 1, MAX_AXES));
         pick = $urandom_range(99);
         if (pick < 75) begin
            for (int a = 0; a < nax; a++)
               send_draw(3'(a), pick_uniform());
            done += nax;
         end else if (pick < 82) begin
            send_draw(3'($urandom_range(7)), pick_uniform());
            done++;
         end else if (pick < 90) begin
            b = 7'($urandom);
            val = $urandom_range(1) ? 25'($urandom) : (25'(b) << 18);
            send_edge(3'($urandom_range(7)), b, val);
            if (b >= 1 && b <= MAX_BINS)
               done++;
         end else if (pick < 96) begin
            send_axis(3'($urandom_range(7)), $urandom, $urandom);
            done++;
         end else begin
            send_item(FUNC_UNKNOWN, any_fields());
         end
      end
   endtask

   task automatic run_phase(input logic [6:0] nb, input logic [6:0] ns, input logic [15:0] np,
                            input logic [3:0] na, input logic [47:0] jac,
                            input logic [23:0] stp, input int count);
      wait_quiet();
      set_register(REG_BINS, 64'(nb));
      set_register(REG_STRATA, 64'(ns));
      set_register(REG_POINTS, 64'(np));
      set_register(REG_AXES, 64'(na));
      set_register(REG_JACOB, 64'(jac));
      set_register(REG_STEP, 64'(stp));
      n_settings++;
      random_traffic(count);
   endtask

   task automatic test_config_phases();
      logic [6:0] nb, ns;
      req_idle_pct = 35;
      rsp_idle_pct = 50;
      run_phase(7'd64, 7'd2, 16'd2, 4'd3, 48'h1_0000_0000, 24'h20_0000, 120);
      run_phase(7'd1, 7'd1, 16'd0, 4'd1, 48'hFFFF_FFFF_FFFF, 24'h00_0000, 120);
      run_phase(7'd127, 7'd127, 16'hFFFF, 4'd15, 48'h0, 24'hFF_FFFF, 120);
      req_idle_pct = 50;
      rsp_idle_pct = 35;
      run_phase(7'd16, 7'd3, 16'd1, 4'd2, 48'({$urandom, $urandom}),
                24'(16 * 65536 / 3), 120);
      run_phase(7'd0, 7'd0, 16'd3, 4'd0, 48'({$urandom, $urandom}), 24'($urandom), 120);
      run_phase(7'd64, 7'd64, 16'd2, 4'd8, 48'h1_0000_0000, 24'h01_0000, 120);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      nb = 7'($urandom_range(64, 1));
      ns = 7'($urandom_range(4, 1));
      run_phase(nb, ns, 16'($urandom_range(5, 2)), 4'($urandom_range(8, 1)),
                48'({$urandom, $urandom}), 24'((int'(nb) * 65536) / int'(ns)), 120);
      run_phase(7'd32, 7'd4, 16'd2, 4'd4, 48'h0_4000_0000, 24'h08_0000, 120);
   endtask

   // result side held off for a long stretch while items keep coming
   task automatic test_backpressure();
      hold_requests++;
      random_traffic(60);
      wait_quiet();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_grid_load();
      test_directed();
      test_config_phases();
      test_backpressure();
      wait_quiet();
      $display("Run covered %0d draws and %0d write or unknown items over %0d settings.",
               n_draws, n_writes, n_settings);
      $display("Cells finished %0d times, sweep flag seen on %0d results, %0d errors.",
               n_wraps, n_sweeps, errors);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
